// ----- hw/rtl/bdc_pkg.sv -----
// Shared widths, register indexes and helpers for the brush dab compositor.
package bdc_pkg;

  localparam int RAD_W     = 7;
  localparam int FR_W      = 9;
  localparam int CH_W      = 8;
  localparam int COLOR_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;
  localparam int ACC_W     = 19;
  localparam int MIX_W     = 17;
  localparam int LANES     = 6;

  localparam int LANE_RAD = 0;
  localparam int LANE_HRD = 1;
  localparam int LANE_OPA = 2;
  localparam int LANE_RED = 3;
  localparam int LANE_GRN = 4;
  localparam int LANE_BLU = 5;

  localparam logic [FR_W-1:0] UNIT = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS_FULL   = 3'd0,
    CFG_RADIUS_ZERO   = 3'd1,
    CFG_HARDNESS_FULL = 3'd2,
    CFG_HARDNESS_ZERO = 3'd3,
    CFG_OPACITY_FULL  = 3'd4,
    CFG_OPACITY_ZERO  = 3'd5,
    CFG_COLOR_FULL    = 3'd6,
    CFG_COLOR_ZERO    = 3'd7
  } cfg_idx_t;

  function automatic logic [FR_W-1:0] sat_unit(input logic [FR_W-1:0] v);
    return (v > UNIT) ? UNIT : v;
  endfunction

endpackage

// ----- hw/rtl/brush_dab_compositor_unit.sv -----
// Top level of the brush dab compositor: dab setup, falloff ramp and pixel blend.
//
//  channel | ports                                   | direction
//  in      | in_valid, in_stall, in_action..in_dest_*| item in
//  out     | out_valid, out_stall, out_dab_radius..  | result out
//  cfg     | cfg_wr_en, cfg_index, cfg_data          | register write
//
// Begin item: mix (one pressure bit a cycle), setup, division, ramp fill of 2*radius
// entries (one write a cycle) and result load.
// Pixel item: fold/square, root (one root bit a cycle), ramp read, blend
// (one channel a cycle) and result load; the block returns to idle after each item.
// Reset is synchronous, active low. One result register parts the sides: a
// new item is taken while a result waits; out_stall holds only the final step.
module brush_dab_compositor_unit
  import bdc_pkg::*;
#(
  parameter int MAX_RADIUS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [FR_W-1:0]      in_pressure,
  input  logic [RAD_W-1:0]     in_col,
  input  logic [RAD_W-1:0]     in_row,
  input  logic [CH_W-1:0]      in_dest_red,
  input  logic [CH_W-1:0]      in_dest_green,
  input  logic [CH_W-1:0]      in_dest_blue,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RAD_W-1:0]     out_dab_radius,
  output logic [CH_W-1:0]      out_new_red,
  output logic [CH_W-1:0]      out_new_green,
  output logic [CH_W-1:0]      out_new_blue,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int RAD_CAP    = (MAX_RADIUS > 127) ? 127 : MAX_RADIUS;
  localparam int RAMP_DEPTH = 2 * RAD_CAP;
  localparam int IDX_W      = (RAMP_DEPTH > 2) ? $clog2(RAMP_DEPTH) : 1;
  localparam logic [RAD_W-1:0] RAD_MAX = RAD_W'(RAD_CAP);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MIX, ST_SCALE, ST_PALPHA, ST_GRAD, ST_DIV, ST_FILL,
    ST_FOLD, ST_SQX, ST_SQY, ST_ROOT, ST_LOOK, ST_READ, ST_BLEND, ST_DONE
  } state_t;

  // configuration
  logic [RAD_W-1:0]   radius_full_r, radius_zero_r;
  logic [FR_W-1:0]    hardness_full_r, hardness_zero_r;
  logic [FR_W-1:0]    opacity_full_r, opacity_zero_r;
  logic [COLOR_W-1:0] color_full_r, color_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_full_r   <= '0;
      radius_zero_r   <= '0;
      hardness_full_r <= UNIT;
      hardness_zero_r <= UNIT;
      opacity_full_r  <= UNIT;
      opacity_zero_r  <= UNIT;
      color_full_r    <= '0;
      color_zero_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RADIUS_FULL:   radius_full_r   <= cfg_data[RAD_W-1:0];
        CFG_RADIUS_ZERO:   radius_zero_r   <= cfg_data[RAD_W-1:0];
        CFG_HARDNESS_FULL: hardness_full_r <= cfg_data[FR_W-1:0];
        CFG_HARDNESS_ZERO: hardness_zero_r <= cfg_data[FR_W-1:0];
        CFG_OPACITY_FULL:  opacity_full_r  <= cfg_data[FR_W-1:0];
        CFG_OPACITY_ZERO:  opacity_zero_r  <= cfg_data[FR_W-1:0];
        CFG_COLOR_FULL:    color_full_r    <= cfg_data[COLOR_W-1:0];
        CFG_COLOR_ZERO:    color_zero_r    <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  state_t             state_r;
  logic [3:0]         cnt_r;
  logic [FR_W-1:0]    p_sr_r;
  logic signed [ACC_W-1:0] acc_r [LANES];
  logic [RAD_W-1:0]   dab_rad_r;
  logic [COLOR_W-1:0] dab_color_r;
  logic [FR_W-1:0]    point_alpha_r;
  logic [FR_W-1:0]    h_r, o_r;
  logic [7:0]         grad_r;
  logic [FR_W-1:0]    dnum_sr_r, dq_r;
  logic [7:0]         drem_r;
  logic [7:0]         i_r;
  logic [FR_W:0]      q_r;
  logic [7:0]         rm_r;
  logic [RAD_W-1:0]   col_r, row_r;
  logic               inside_r, hit_r;
  logic [7:0]         dx_r, dy_r;
  logic [15:0]        sqx_r;
  logic [17:0]        s_sr_r;
  logic [10:0]        rem_r;
  logic [8:0]         root_r;
  logic [FR_W-1:0]    ramp_q_r, alpha_r;
  logic [COLOR_W-1:0] dest_sr_r, color_sr_r, res_sr_r;
  logic               out_valid_r;
  logic [RAD_W-1:0]   out_rad_r;
  logic [COLOR_W-1:0] out_rgb_r;

  logic [FR_W-1:0]    ramp_mem [RAMP_DEPTH];

  // setup datapath
  logic [FR_W-1:0]         lane_full [LANES];
  logic [FR_W-1:0]         lane_zero [LANES];
  logic signed [9:0]       lane_diff [LANES];
  logic [MIX_W-1:0]        mix_u [LANES];
  logic signed [ACC_W-1:0] mix_s [LANES];
  logic [9:0]              rad_ceil;
  logic [RAD_W-1:0]        rad_sel;
  logic [MIX_W-1:0]        ch_round [LANES];
  logic [17:0]             pa_prod;
  logic [16:0]             g_prod;
  logic [7:0]              len;
  logic [8:0]              div_sh;
  logic [8:0]              rm_sum;
  logic [FR_W-1:0]         fill_v;

  always_comb begin
    lane_full[LANE_RAD] = {2'b00, radius_full_r};
    lane_zero[LANE_RAD] = {2'b00, radius_zero_r};
    lane_full[LANE_HRD] = sat_unit(hardness_full_r);
    lane_zero[LANE_HRD] = sat_unit(hardness_zero_r);
    lane_full[LANE_OPA] = sat_unit(opacity_full_r);
    lane_zero[LANE_OPA] = sat_unit(opacity_zero_r);
    lane_full[LANE_RED] = {1'b0, color_full_r[23:16]};
    lane_zero[LANE_RED] = {1'b0, color_zero_r[23:16]};
    lane_full[LANE_GRN] = {1'b0, color_full_r[15:8]};
    lane_zero[LANE_GRN] = {1'b0, color_zero_r[15:8]};
    lane_full[LANE_BLU] = {1'b0, color_full_r[7:0]};
    lane_zero[LANE_BLU] = {1'b0, color_zero_r[7:0]};
    for (int k = 0; k < LANES; k++) begin
      lane_diff[k] = $signed({1'b0, lane_full[k]}) - $signed({1'b0, lane_zero[k]});
      mix_s[k]     = acc_r[k] + $signed({2'b00, lane_zero[k], 8'h00});
      mix_u[k]     = mix_s[k][MIX_W-1:0];
      ch_round[k]  = mix_u[k] + 17'd128;
    end
    rad_ceil = 10'((18'(mix_u[LANE_RAD]) + 18'd255) >> 8);
    rad_sel  = (rad_ceil > 10'(RAD_CAP)) ? RAD_MAX : rad_ceil[RAD_W-1:0];
    pa_prod  = 18'(o_r) * 18'(h_r);
    len      = {dab_rad_r, 1'b0};
    g_prod   = 17'(UNIT - h_r) * 17'(len);
    div_sh   = {drem_r, dnum_sr_r[FR_W-1]};
    rm_sum   = {1'b0, rm_r} + {1'b0, drem_r};
    fill_v   = (i_r < grad_r) ? q_r[FR_W-1:0] : o_r;
  end

  // pixel datapath
  logic [7:0]         fx, fy;
  logic [12:0]        rt_sh, rt_trial;
  logic [9:0]         root_inc;
  logic [8:0]         rdist;
  logic [RAD_W-1:0]   rad_gap;
  logic [7:0]         rd_idx;
  logic signed [8:0]  bl_diff;
  logic signed [18:0] bl_prod, bl_adj, bl_q;
  logic [CH_W-1:0]    bl_new;

  always_comb begin
    fx       = ({1'b0, col_r} < {1'b0, dab_rad_r}) ? {1'b0, col_r} : len - 8'd1 - {1'b0, col_r};
    fy       = ({1'b0, row_r} < {1'b0, dab_rad_r}) ? {1'b0, row_r} : len - 8'd1 - {1'b0, row_r};
    rt_sh    = {rem_r, s_sr_r[17:16]};
    rt_trial = {2'b00, root_r, 2'b01};
    root_inc = {1'b0, root_r} + 10'd1;
    rdist    = root_inc[9:1];
    rad_gap  = dab_rad_r - rdist[RAD_W-1:0];
    rd_idx   = {rad_gap, 1'b0};
    bl_diff  = $signed({1'b0, color_sr_r[23:16]}) - $signed({1'b0, dest_sr_r[23:16]});
    bl_prod  = 19'($signed({1'b0, alpha_r})) * 19'(bl_diff);
    bl_adj   = bl_prod[18] ? bl_prod + 19'sd255 : bl_prod;
    bl_q     = bl_adj >>> 8;
    bl_new   = dest_sr_r[23:16] + bl_q[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FILL) begin
      ramp_mem[i_r[IDX_W-1:0]] <= fill_v;
    end
    ramp_q_r <= ramp_mem[rd_idx[IDX_W-1:0]];
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_dab_radius = out_rad_r;
  assign out_new_red    = out_rgb_r[23:16];
  assign out_new_green  = out_rgb_r[15:8];
  assign out_new_blue   = out_rgb_r[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      dab_rad_r     <= '0;
      dab_color_r   <= '0;
      point_alpha_r <= '0;
      cnt_r         <= '0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            dest_sr_r <= {in_dest_red, in_dest_green, in_dest_blue};
            col_r     <= in_col;
            row_r     <= in_row;
            res_sr_r  <= '0;
            cnt_r     <= 4'd8;
            p_sr_r    <= sat_unit(in_pressure);
            for (int k = 0; k < LANES; k++) begin
              acc_r[k] <= '0;
            end
            state_r <= in_action ? ST_FOLD : ST_MIX;
          end
        end
        ST_MIX: begin
          for (int k = 0; k < LANES; k++) begin
            acc_r[k] <= (acc_r[k] <<< 1) + (p_sr_r[FR_W-1] ? ACC_W'(lane_diff[k]) : '0);
          end
          p_sr_r <= p_sr_r << 1;
          cnt_r  <= cnt_r - 4'd1;
          if (cnt_r == '0) begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          dab_rad_r   <= rad_sel;
          h_r         <= mix_u[LANE_HRD][16:8];
          o_r         <= mix_u[LANE_OPA][16:8];
          dab_color_r <= {ch_round[LANE_RED][15:8], ch_round[LANE_GRN][15:8],
                          ch_round[LANE_BLU][15:8]};
          state_r     <= ST_PALPHA;
        end
        ST_PALPHA: begin
          point_alpha_r <= pa_prod[16:8];
          state_r       <= ST_GRAD;
        end
        ST_GRAD: begin
          grad_r    <= g_prod[15:8];
          dnum_sr_r <= o_r;
          drem_r    <= '0;
          dq_r      <= '0;
          cnt_r     <= 4'd8;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          if (div_sh >= {1'b0, grad_r}) begin
            drem_r <= 8'(div_sh - {1'b0, grad_r});
            dq_r   <= {dq_r[FR_W-2:0], 1'b1};
          end else begin
            drem_r <= div_sh[7:0];
            dq_r   <= {dq_r[FR_W-2:0], 1'b0};
          end
          dnum_sr_r <= dnum_sr_r << 1;
          cnt_r     <= cnt_r - 4'd1;
          if (cnt_r == '0) begin
            i_r     <= '0;
            q_r     <= '0;
            rm_r    <= '0;
            state_r <= (len == '0) ? ST_DONE : ST_FILL;
          end
        end
        ST_FILL: begin
          if (rm_sum >= {1'b0, grad_r}) begin
            rm_r <= 8'(rm_sum - {1'b0, grad_r});
            q_r  <= q_r + {1'b0, dq_r} + 10'd1;
          end else begin
            rm_r <= rm_sum[7:0];
            q_r  <= q_r + {1'b0, dq_r};
          end
          i_r <= i_r + 8'd1;
          if (i_r == len - 8'd1) begin
            state_r <= ST_DONE;
          end
        end
        ST_FOLD: begin
          inside_r <= ({1'b0, col_r} < len) && ({1'b0, row_r} < len);
          dx_r     <= len - {fx[6:0], 1'b0} - 8'd1;
          dy_r     <= len - {fy[6:0], 1'b0} - 8'd1;
          state_r  <= ST_SQX;
        end
        ST_SQX: begin
          sqx_r   <= 16'(dx_r) * 16'(dx_r);
          state_r <= ST_SQY;
        end
        ST_SQY: begin
          s_sr_r  <= {1'b0, 17'(sqx_r) + 17'(dy_r) * 17'(dy_r)};
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= 4'd8;
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if (rt_sh >= rt_trial) begin
            rem_r  <= 11'(rt_sh - rt_trial);
            root_r <= {root_r[7:0], 1'b1};
          end else begin
            rem_r  <= rt_sh[10:0];
            root_r <= {root_r[7:0], 1'b0};
          end
          s_sr_r <= s_sr_r << 2;
          cnt_r  <= cnt_r - 4'd1;
          if (cnt_r == '0) begin
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          hit_r    <= inside_r && (dab_rad_r != '0) && (rdist < {2'b00, dab_rad_r});
          state_r  <= ST_READ;
        end
        ST_READ: begin
          if (dab_rad_r == '0) begin
            alpha_r <= point_alpha_r;
          end else begin
            alpha_r <= hit_r ? ramp_q_r : '0;
          end
          color_sr_r <= dab_color_r;
          cnt_r      <= 4'd2;
          state_r    <= ST_BLEND;
        end
        ST_BLEND: begin
          res_sr_r   <= {res_sr_r[15:0], bl_new};
          dest_sr_r  <= dest_sr_r << CH_W;
          color_sr_r <= color_sr_r << CH_W;
          cnt_r      <= cnt_r - 4'd1;
          if (cnt_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_rad_r   <= dab_rad_r;
            out_rgb_r   <= res_sr_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/bdc_checker.sv -----
// Port-level checks for the brush dab compositor, bound to the top level.
module bdc_checker
  import bdc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [RAD_W-1:0] out_dab_radius,
  input logic [CH_W-1:0]  out_new_red
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_dab_radius) && $stable(out_new_red))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block free right after taking an item");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && !out_valid |=> !out_valid)
    else $error("result without an item");

endmodule

bind brush_dab_compositor_unit bdc_checker u_bdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_dab_radius(out_dab_radius),
  .out_new_red   (out_new_red)
);
